// ===== rtl/gpe_pkg.sv =====
// Shared types, constants and fixed-point helpers of the GRU predictive error core.
package gpe_pkg;

	localparam int VAL_W = 16;
	localparam int MSE_W = 32;
	localparam int OPD_W = 18;
	localparam int PRD_W = 2 * OPD_W;
	localparam int ACC_W = 40;
	localparam int GATE_W = 13;
	localparam logic [GATE_W-1:0] ONE_Q12 = 13'd4096;

	typedef enum logic {
		CMD_WEIGHT = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		MAT_IR   = 3'd0,
		MAT_HR   = 3'd1,
		MAT_IZ   = 3'd2,
		MAT_HZ   = 3'd3,
		MAT_IN   = 3'd4,
		MAT_HN   = 3'd5,
		MAT_PRED = 3'd6
	} mat_t;

	localparam logic [GATE_W-1:0] SIG_TABLE [17] = '{
		13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902,
		13'd3976, 13'd4022, 13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090,
		13'd4092, 13'd4094, 13'd4095
	};

	// Round by half an LSB, floor shift by 12, saturate to Q4.12.
	function automatic logic signed [VAL_W-1:0] narrow(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] q;
		v = acc + ACC_W'(2048);
		q = v >>> 12;
		if (q > ACC_W'(32767))
			return 16'sh7fff;
		else if (q < -ACC_W'(32768))
			return 16'sh8000;
		else
			return q[VAL_W-1:0];
	endfunction

	// Sigmoid by table and linear interpolation over the magnitude.
	function automatic logic [GATE_W-1:0] sig_fx(input logic signed [VAL_W-1:0] x);
		logic [VAL_W-1:0] a;
		logic [4:0] idx;
		logic [10:0] frac;
		logic [GATE_W-1:0] lo;
		logic [GATE_W-1:0] hi;
		logic [21:0] step;
		logic [GATE_W-1:0] val;
		a = x[VAL_W-1] ? (~x + 16'd1) : x;
		idx = a[15:11];
		frac = a[10:0];
		if (idx >= 5'd16) begin
			val = SIG_TABLE[16];
		end else begin
			lo = SIG_TABLE[idx[3:0]];
			hi = SIG_TABLE[5'(idx + 5'd1)];
			step = (22'(hi - lo) * 22'(frac) + 22'd1024) >> 11;
			val = lo + step[GATE_W-1:0];
		end
		return x[VAL_W-1] ? (ONE_Q12 - val) : val;
	endfunction

	// tanh(x) = 2 * sig(sat16(2x)) - 1.
	function automatic logic signed [VAL_W-1:0] tanh_fx(input logic signed [VAL_W-1:0] x);
		logic signed [VAL_W:0] d;
		logic signed [VAL_W-1:0] ds;
		logic [GATE_W-1:0] s;
		d = {x, 1'b0};
		if (d > 17'sd32767)
			ds = 16'sh7fff;
		else if (d < -17'sd32768)
			ds = 16'sh8000;
		else
			ds = d[VAL_W-1:0];
		s = sig_fx(ds);
		return $signed({2'b00, s, 1'b0}) - 16'sd4096;
	endfunction

endpackage

// ===== rtl/gpe_in_if.sv =====
// Input channel: weight words and samples with valid/ready.
interface gpe_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [2:0]  matrix_sel;
	logic [3:0]  row;
	logic [3:0]  col;
	logic signed [15:0] value;

	modport source (output valid, cmd, matrix_sel, row, col, value, input ready);
	modport sink (input valid, cmd, matrix_sel, row, col, value, output ready);
endinterface

// ===== rtl/gpe_out_if.sv =====
// Output channel: mean squared error results with valid/ready.
interface gpe_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] mse;

	modport source (output valid, mse, input ready);
	modport sink (input valid, mse, output ready);
endinterface

// ===== rtl/gru_predictive_error_core.sv =====
// GRU cell with a linear prediction head on one shared multiply-accumulate unit.
//
//  channel | dir | payload                               | accepted when
//  load    | in  | cmd, matrix_sel, row, col, value      | valid && ready
//  result  | out | mse (Q16.16)                          | valid && ready
//
// A weight item or a sample that does not complete the vector is taken while idle.
// The last sample of a vector starts the run. Each hidden row runs five phases with
// 3I+3H+3 MAC terms in all, and every phase adds a drain step and a finishing step;
// each output then runs two phases with H+1 terms and the same overhead; a
// reciprocal-multiply step and a done step close the vector. All MAC terms stream
// through one 18x18 multiplier fed by the weight memory read port or by core
// registers. Load is not ready during the run, and the done step stretches while an
// earlier result still waits to be taken.
// Reset clears the hidden vector and the sample count; weights are not cleared.
// A result waits in its output register while new items are taken.
module gru_predictive_error_core
	import gpe_pkg::*;
#(
	parameter int NUM_IN = 8,
	parameter int NUM_HID = 16
) (
	input  logic clk,
	input  logic arst_n,
	gpe_in_if.sink    load,
	gpe_out_if.source result
);

	localparam int MAT_IH = NUM_IN * NUM_HID;
	localparam int MAT_HH = NUM_HID * NUM_HID;
	localparam int DEPTH = 4 * MAT_IH + 3 * MAT_HH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
	localparam int HW = (NUM_HID > 1) ? $clog2(NUM_HID) : 1;
	localparam int MAXD = (NUM_IN > NUM_HID) ? NUM_IN : NUM_HID;
	localparam int IW = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int KW = $clog2(NUM_IN + NUM_HID + 1);
	localparam int CW = $clog2(NUM_IN + 1);
	localparam int OFF_IR = 0;
	localparam int OFF_HR = MAT_IH;
	localparam int OFF_IZ = MAT_IH + MAT_HH;
	localparam int OFF_HZ = 2 * MAT_IH + MAT_HH;
	localparam int OFF_IN = 2 * MAT_IH + 2 * MAT_HH;
	localparam int OFF_HN = 3 * MAT_IH + 2 * MAT_HH;
	localparam int OFF_PRED = 3 * MAT_IH + 3 * MAT_HH;
	// Scaled error sum stays below 2^28; divide by NUM_IN with a rounded-up reciprocal.
	localparam int QN = 28;
	localparam int SH_L = $clog2(NUM_IN);
	localparam int RW = QN + 1;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << (QN + SH_L)) + 64'(NUM_IN - 1)) / 64'(NUM_IN));

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FIN, ST_DIV, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_R, PH_Z, PH_H, PH_N, PH_U, PH_P, PH_D
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [KW-1:0] k_q;
	logic [IW-1:0] i_q;
	logic [CW-1:0] cnt_q;

	logic signed [VAL_W-1:0] wmem [DEPTH];
	logic signed [VAL_W-1:0] rd_q;
	logic signed [VAL_W-1:0] x_q [NUM_IN];
	logic signed [VAL_W-1:0] h_q [NUM_HID];
	logic signed [VAL_W-1:0] hs_q [NUM_HID];

	logic vld_s1, vld_s2, use_mem_s1;
	logic signed [OPD_W-1:0] a_s1, b_s1;
	logic signed [PRD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] sum_q;
	logic [GATE_W-1:0] r_q, z_q;
	logic signed [VAL_W-1:0] qv_q, n_q;
	logic signed [VAL_W:0] d_q;
	logic [MSE_W-1:0] quo_q;
	logic out_valid_q;
	logic [MSE_W-1:0] mse_q;

	logic in_acc, we, legal;
	logic [AW-1:0] waddr, raddr;
	logic [KW-1:0] nterms, kh;
	logic use_mem;
	logic signed [OPD_W-1:0] a_op, b_op;
	logic signed [OPD_W-1:0] op_a;
	logic signed [VAL_W-1:0] acc_n;
	logic [ACC_W-1:0] sum_r;
	logic [QN-1:0] num_d;
	logic [QN+RW-1:0] scaled;

	assign load.ready = (state_q == ST_IDLE);
	assign in_acc = load.valid && load.ready;
	assign result.valid = out_valid_q;
	assign result.mse = mse_q;
	assign acc_n = narrow(acc_q);

	// Decode the weight write address and range check.
	always_comb begin
		int rows, cols, off;
		rows = NUM_HID;
		cols = NUM_HID;
		off = 0;
		legal = 1'b1;
		case (load.matrix_sel)
			MAT_IR: begin cols = NUM_IN; off = OFF_IR; end
			MAT_HR: off = OFF_HR;
			MAT_IZ: begin cols = NUM_IN; off = OFF_IZ; end
			MAT_HZ: off = OFF_HZ;
			MAT_IN: begin cols = NUM_IN; off = OFF_IN; end
			MAT_HN: off = OFF_HN;
			MAT_PRED: begin rows = NUM_IN; off = OFF_PRED; end
			default: legal = 1'b0;
		endcase
		if (int'(load.row) >= rows || int'(load.col) >= cols)
			legal = 1'b0;
		waddr = AW'(off) + AW'(load.row) * AW'(cols) + AW'(load.col);
		we = in_acc && (load.cmd == CMD_WEIGHT) && legal;
	end

	// Select the term issued this cycle: weight address and operands.
	always_comb begin
		kh = k_q - KW'(NUM_IN);
		nterms = KW'(NUM_IN + NUM_HID);
		raddr = '0;
		use_mem = 1'b1;
		a_op = '0;
		b_op = '0;
		case (phase_q)
			PH_R, PH_Z: begin
				if (k_q < KW'(NUM_IN)) begin
					raddr = AW'((phase_q == PH_R) ? OFF_IR : OFF_IZ)
						+ AW'(i_q) * AW'(NUM_IN) + AW'(k_q);
					b_op = OPD_W'(x_q[k_q[XW-1:0]]);
				end else begin
					raddr = AW'((phase_q == PH_R) ? OFF_HR : OFF_HZ)
						+ AW'(i_q) * AW'(NUM_HID) + AW'(kh);
					b_op = OPD_W'(h_q[kh[HW-1:0]]);
				end
			end
			PH_H: begin
				nterms = KW'(NUM_HID);
				raddr = AW'(OFF_HN) + AW'(i_q) * AW'(NUM_HID) + AW'(k_q);
				b_op = OPD_W'(h_q[k_q[HW-1:0]]);
			end
			PH_N: begin
				nterms = KW'(NUM_IN + 1);
				raddr = AW'(OFF_IN) + AW'(i_q) * AW'(NUM_IN) + AW'(k_q);
				if (k_q < KW'(NUM_IN)) begin
					b_op = OPD_W'(x_q[k_q[XW-1:0]]);
				end else begin
					use_mem = 1'b0;
					a_op = OPD_W'({1'b0, r_q});
					b_op = OPD_W'(qv_q);
				end
			end
			PH_U: begin
				nterms = KW'(2);
				use_mem = 1'b0;
				if (k_q == '0) begin
					a_op = OPD_W'({1'b0, ONE_Q12 - z_q});
					b_op = OPD_W'(n_q);
				end else begin
					a_op = OPD_W'({1'b0, z_q});
					b_op = OPD_W'(h_q[i_q[HW-1:0]]);
				end
			end
			PH_P: begin
				nterms = KW'(NUM_HID);
				raddr = AW'(OFF_PRED) + AW'(i_q) * AW'(NUM_HID) + AW'(k_q);
				b_op = OPD_W'(hs_q[k_q[HW-1:0]]);
			end
			PH_D: begin
				nterms = KW'(1);
				use_mem = 1'b0;
				a_op = OPD_W'(d_q);
				b_op = OPD_W'(d_q);
			end
			default: nterms = KW'(1);
		endcase
	end

	// Weight memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we)
			wmem[waddr] <= load.value;
		rd_q <= wmem[raddr];
	end

	// MAC pipeline: operands, product, accumulate.
	assign op_a = use_mem_s1 ? OPD_W'(rd_q) : a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_ISSUE);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		use_mem_s1 <= use_mem;
		a_s1 <= a_op;
		b_s1 <= b_op;
		prod_s2 <= op_a * b_s1;
	end

	// Round the error sum, drop 8 fraction bits, divide by the vector length.
	assign sum_r = sum_q + ACC_W'(128 * NUM_IN);
	assign num_d = sum_r[QN+7:8];
	assign scaled = num_d * RECIP;

	// Hold the hidden vector; clear at reset, replace at end of the vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_HID; j++)
				h_q[j] <= '0;
		end else if (state_q == ST_FIN && phase_q == PH_D
			&& i_q == IW'(NUM_IN - 1)) begin
			for (int j = 0; j < NUM_HID; j++)
				h_q[j] <= hs_q[j];
		end
	end

	// Data path registers written by the sequencer.
	always_ff @(posedge clk) begin
		if (in_acc && load.cmd == CMD_SAMPLE)
			x_q[cnt_q[XW-1:0]] <= load.value;
		if (state_q == ST_IDLE) begin
			acc_q <= '0;
			sum_q <= '0;
		end else if (state_q == ST_FIN) begin
			acc_q <= '0;
			if (phase_q == PH_D)
				sum_q <= sum_q + acc_q;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == ST_FIN) begin
			case (phase_q)
				PH_R: r_q <= sig_fx(acc_n);
				PH_Z: z_q <= sig_fx(acc_n);
				PH_H: qv_q <= acc_n;
				PH_N: n_q <= tanh_fx(acc_n);
				PH_U: hs_q[i_q[HW-1:0]] <= acc_n;
				PH_P: d_q <= {acc_n[VAL_W-1], acc_n}
					- {x_q[i_q[XW-1:0]][VAL_W-1], x_q[i_q[XW-1:0]]};
				default: ;
			endcase
		end else if (state_q == ST_DIV) begin
			quo_q <= MSE_W'(scaled[QN+RW-1:QN+SH_L]);
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_R;
			k_q <= '0;
			i_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			mse_q <= '0;
		end else begin
			// Raise the result when the done step hands it over, drop it once taken.
			if (state_q == ST_DONE && (!out_valid_q || result.ready))
				out_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && load.cmd == CMD_SAMPLE) begin
						if (cnt_q == CW'(NUM_IN - 1)) begin
							cnt_q <= '0;
							state_q <= ST_ISSUE;
							phase_q <= PH_R;
							k_q <= '0;
							i_q <= '0;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_ISSUE: begin
					if (k_q == nterms - KW'(1))
						state_q <= ST_DRAIN;
					else
						k_q <= k_q + KW'(1);
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					k_q <= '0;
					state_q <= ST_ISSUE;
					case (phase_q)
						PH_R: phase_q <= PH_Z;
						PH_Z: phase_q <= PH_H;
						PH_H: phase_q <= PH_N;
						PH_N: phase_q <= PH_U;
						PH_U: begin
							if (i_q == IW'(NUM_HID - 1)) begin
								i_q <= '0;
								phase_q <= PH_P;
							end else begin
								i_q <= i_q + IW'(1);
								phase_q <= PH_R;
							end
						end
						PH_P: phase_q <= PH_D;
						PH_D: begin
							if (i_q == IW'(NUM_IN - 1)) begin
								state_q <= ST_DIV;
							end else begin
								i_q <= i_q + IW'(1);
								phase_q <= PH_P;
							end
						end
						default: phase_q <= PH_R;
					endcase
				end
				ST_DIV: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						mse_q <= quo_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !vld_s1 && !vld_s2)
		else $error("finishing step with MAC terms in flight");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(NUM_IN))
		else $error("sample count out of range");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done step");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && !result.ready |=> state_q == ST_DONE)
		else $error("pending result overwritten");
`endif

endmodule
